>>> hw/rtl/gaze_animated_eye_overlay_unit_defines.svh
// assertion macros used by the port-level checker file
`ifndef GAZE_ANIMATED_EYE_OVERLAY_UNIT_DEFINES_SVH
`define GAZE_ANIMATED_EYE_OVERLAY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GAEO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gaeo same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define GAEO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gaeo next-cycle check failed");

`endif

>>> hw/rtl/gaeo_pkg.sv
// shared types, constants and gaze table for the eye overlay unit
package gaeo_pkg;

  localparam int MOVE_TICKS_DEF = 700;
  localparam int GAZE_COUNT     = 5;
  localparam int GAZE_SLOTS     = 8;
  localparam int GAZE_IDX_W     = 3;
  localparam int GAZE_SWING     = 12;
  localparam int MAX_DELTA      = 2 * GAZE_SWING;

  localparam int BAND_MIN_X = 17;
  localparam int BAND_MIN_Y = 50;
  localparam int BAND_END_X = 213;
  localparam int BAND_END_Y = 200;

  localparam logic [15:0] RING_RGB = 16'hF800;
  localparam logic [15:0] DISC_RGB = 16'h7800;

  localparam logic signed [5:0] GAZE_DX [GAZE_SLOTS] =
    '{6'sd0, -6'sd12, 6'sd12, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0};
  localparam logic signed [5:0] GAZE_DY [GAZE_SLOTS] =
    '{6'sd0, 6'sd0, 6'sd0, 6'sd10, -6'sd10, 6'sd0, 6'sd0, 6'sd0};

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_RAD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EYE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EYE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_CENTRE_Y = 3'd5;

  localparam logic [15:0] RST_PAUSE_TICKS  = 16'd3000;
  localparam logic [5:0]  RST_DISC_RAD     = 6'd24;
  localparam logic [3:0]  RST_BORDER_WIDTH = 4'd4;
  localparam logic [7:0]  RST_LEFT_EYE_X   = 8'd70;
  localparam logic [7:0]  RST_RIGHT_EYE_X  = 8'd160;
  localparam logic [7:0]  RST_EYE_CENTRE_Y = 8'd160;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef logic signed [10:0] coord_t;

  typedef enum logic [1:0] {
    COV_NONE   = 2'd0,
    COV_FILL   = 2'd1,
    COV_BORDER = 2'd2
  } cov_t;

  typedef struct packed {
    logic [15:0] pause_ticks;
    logic [5:0]  disc_rad;
    logic [3:0]  border_width;
    logic [7:0]  left_eye_x;
    logic [7:0]  right_eye_x;
    logic [7:0]  eye_centre_y;
  } cfg_t;

  typedef struct packed {
    logic signed [5:0] x;
    logic signed [5:0] y;
  } offs_t;

  typedef struct packed {
    coord_t      x0;
    coord_t      x1;
    coord_t      y0;
    coord_t      y1;
    coord_t      exl;
    coord_t      exr;
    coord_t      cy;
    logic [12:0] r2;
    logic [12:0] rb2;
  } geom_t;

endpackage

>>> hw/rtl/gaeo_gaze.sv
// gaze animation: rest counter, move sequencing and incremental interpolation
module gaeo_gaze #(
  parameter int MOVE_TICKS = gaeo_pkg::MOVE_TICKS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick,
  input  logic [15:0]     pause_ticks,
  output gaeo_pkg::offs_t ofs
);

  localparam int REM_W = (MOVE_TICKS > 1) ? $clog2(2 * MOVE_TICKS) : 1;
  localparam int GW    = gaeo_pkg::GAZE_IDX_W;

  logic signed [6:0]  step_qx [gaeo_pkg::GAZE_SLOTS];
  logic signed [6:0]  step_qy [gaeo_pkg::GAZE_SLOTS];
  logic [REM_W-1:0]   step_rx [gaeo_pkg::GAZE_SLOTS];
  logic [REM_W-1:0]   step_ry [gaeo_pkg::GAZE_SLOTS];

  // per-tick quotient and remainder step for each move, floor form
  for (genvar g = 0; g < gaeo_pkg::GAZE_SLOTS; g++) begin : g_step
    localparam int NG  = (g + 1) % gaeo_pkg::GAZE_COUNT;
    localparam int DX  = int'(gaeo_pkg::GAZE_DX[NG]) - int'(gaeo_pkg::GAZE_DX[g]);
    localparam int DY  = int'(gaeo_pkg::GAZE_DY[NG]) - int'(gaeo_pkg::GAZE_DY[g]);
    localparam int BX  = DX + gaeo_pkg::MAX_DELTA * MOVE_TICKS;
    localparam int BY  = DY + gaeo_pkg::MAX_DELTA * MOVE_TICKS;
    localparam int DXQ = BX / MOVE_TICKS - gaeo_pkg::MAX_DELTA;
    localparam int DYQ = BY / MOVE_TICKS - gaeo_pkg::MAX_DELTA;
    localparam int DXR = BX % MOVE_TICKS;
    localparam int DYR = BY % MOVE_TICKS;
    assign step_qx[g] = 7'(DXQ);
    assign step_qy[g] = 7'(DYQ);
    assign step_rx[g] = REM_W'(DXR);
    assign step_ry[g] = REM_W'(DYR);
  end

  logic [15:0]             elapsed_r, elapsed_nxt, elapsed_inc;
  logic [GW-1:0]           gaze_now_r, gaze_now_nxt, gaze_next;
  logic                    moving_r, moving_nxt;
  logic signed [5:0]       qx_r, qx_nxt, qy_r, qy_nxt;
  logic [REM_W-1:0]        remx_r, remx_nxt, remy_r, remy_nxt;
  logic [REM_W-1:0]        sumx, sumy;
  logic                    carx, cary;
  logic signed [6:0]       qx_step, qy_step;

  always_comb begin
    elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
    gaze_next   = (gaze_now_r == GW'(gaeo_pkg::GAZE_COUNT - 1)) ? '0 :
                  gaze_now_r + GW'(1);
    sumx    = remx_r + step_rx[gaze_now_r];
    sumy    = remy_r + step_ry[gaze_now_r];
    carx    = (sumx >= REM_W'(MOVE_TICKS));
    cary    = (sumy >= REM_W'(MOVE_TICKS));
    qx_step = 7'(qx_r) + step_qx[gaze_now_r] + {6'd0, carx};
    qy_step = 7'(qy_r) + step_qy[gaze_now_r] + {6'd0, cary};

    elapsed_nxt  = elapsed_r;
    gaze_now_nxt = gaze_now_r;
    moving_nxt   = moving_r;
    qx_nxt       = qx_r;
    qy_nxt       = qy_r;
    remx_nxt     = remx_r;
    remy_nxt     = remy_r;

    if (tick) begin
      elapsed_nxt = elapsed_inc;
      if (!moving_r) begin
        if (elapsed_inc > pause_ticks) begin
          moving_nxt  = 1'b1;
          elapsed_nxt = '0;
          remx_nxt    = '0;
          remy_nxt    = '0;
        end
      end else if (elapsed_inc >= 16'(MOVE_TICKS)) begin
        moving_nxt   = 1'b0;
        elapsed_nxt  = '0;
        gaze_now_nxt = gaze_next;
        qx_nxt       = gaeo_pkg::GAZE_DX[gaze_next];
        qy_nxt       = gaeo_pkg::GAZE_DY[gaze_next];
        remx_nxt     = '0;
        remy_nxt     = '0;
      end else begin
        qx_nxt   = 6'(qx_step);
        qy_nxt   = 6'(qy_step);
        remx_nxt = carx ? sumx - REM_W'(MOVE_TICKS) : sumx;
        remy_nxt = cary ? sumy - REM_W'(MOVE_TICKS) : sumy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      gaze_now_r <= '0;
      moving_r   <= 1'b0;
      qx_r       <= '0;
      qy_r       <= '0;
      remx_r     <= '0;
      remy_r     <= '0;
    end else begin
      elapsed_r  <= elapsed_nxt;
      gaze_now_r <= gaze_now_nxt;
      moving_r   <= moving_nxt;
      qx_r       <= qx_nxt;
      qy_r       <= qy_nxt;
      remx_r     <= remx_nxt;
      remy_r     <= remy_nxt;
    end
  end

  // floor quotient to truncation toward zero
  assign ofs.x = (qx_r < 0 && remx_r != '0) ? qx_r + 6'sd1 : qx_r;
  assign ofs.y = (qy_r < 0 && remy_r != '0) ? qy_r + 6'sd1 : qy_r;

endmodule

>>> hw/rtl/gaeo_geom.sv
// registered eye geometry: clamped band, eye centres and squared radii
module gaeo_geom (
  input  logic            clk,
  input  gaeo_pkg::cfg_t  cfg,
  input  gaeo_pkg::offs_t ofs,
  output gaeo_pkg::geom_t geom
);

  gaeo_pkg::geom_t geom_r, geom_nxt;
  logic [6:0]       rb;
  gaeo_pkg::coord_t rb_c, lx, rx, cy0, bx, bxc, span, x_end, by, byc, y_end;

  always_comb begin
    rb    = 7'(cfg.disc_rad) + 7'(cfg.border_width);
    rb_c  = $signed({4'b0000, rb});
    lx    = $signed({3'b000, cfg.left_eye_x});
    rx    = $signed({3'b000, cfg.right_eye_x});
    cy0   = $signed({3'b000, cfg.eye_centre_y});

    bx    = lx - gaeo_pkg::coord_t'(gaeo_pkg::GAZE_SWING + 1) - rb_c;
    span  = rx - lx + gaeo_pkg::coord_t'(2 * gaeo_pkg::GAZE_SWING + 2) + rb_c + rb_c;
    bxc   = (bx < gaeo_pkg::coord_t'(gaeo_pkg::BAND_MIN_X)) ?
            gaeo_pkg::coord_t'(gaeo_pkg::BAND_MIN_X) : bx;
    x_end = bxc + span;

    by    = cy0 - rb_c - gaeo_pkg::coord_t'(1);
    byc   = (by < gaeo_pkg::coord_t'(gaeo_pkg::BAND_MIN_Y)) ?
            gaeo_pkg::coord_t'(gaeo_pkg::BAND_MIN_Y) : by;
    y_end = byc + rb_c + rb_c + gaeo_pkg::coord_t'(2);

    geom_nxt.x0  = bxc;
    geom_nxt.x1  = (x_end > gaeo_pkg::coord_t'(gaeo_pkg::BAND_END_X)) ?
                   gaeo_pkg::coord_t'(gaeo_pkg::BAND_END_X) : x_end;
    geom_nxt.y0  = byc;
    geom_nxt.y1  = (y_end > gaeo_pkg::coord_t'(gaeo_pkg::BAND_END_Y)) ?
                   gaeo_pkg::coord_t'(gaeo_pkg::BAND_END_Y) : y_end;
    geom_nxt.exl = lx + gaeo_pkg::coord_t'(ofs.x);
    geom_nxt.exr = rx + gaeo_pkg::coord_t'(ofs.x);
    geom_nxt.cy  = cy0 + gaeo_pkg::coord_t'(ofs.y);
    geom_nxt.r2  = {7'd0, cfg.disc_rad} * {7'd0, cfg.disc_rad};
    geom_nxt.rb2 = {6'd0, rb} * {6'd0, rb};
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

>>> hw/rtl/gaze_animated_eye_overlay_unit.sv
// Eye overlay unit: ticks (op 0) step the gaze animation and give no result;
// pixels (op 1) come back shaded with their coverage code, one transfer per
// clock in each direction while input is not held back and results are taken.
// A pixel passes an input register and then a result register, entering the
// result register once it is empty or being taken. A tick updates the gaze
// state at the edge it is taken. Gaze offsets and configuration reach the pixel
// math through the registered geometry. Input is held back only while the input
// register holds a pixel and the result register is full and not taken.
module gaze_animated_eye_overlay_unit #(
  parameter int MOVE_TICKS = gaeo_pkg::MOVE_TICKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gaeo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gaeo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [7:0]                        in_pixel_x,
  input  logic [7:0]                        in_pixel_y,
  input  logic [15:0]                       in_background,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       out_shaded,
  output logic [1:0]                        out_coverage
);

  gaeo_pkg::cfg_t  cfg_r, cfg_nxt;
  gaeo_pkg::offs_t ofs;
  gaeo_pkg::geom_t geom;

  logic        s1_v_r, s1_v_nxt, s1_go, in_xfer, pix_xfer, tick_xfer;
  logic [7:0]  s1_x_r, s1_y_r;
  logic [15:0] s1_bg_r;
  logic        out_v_r, out_v_nxt;
  logic [15:0] out_shaded_r, shaded_nxt;
  gaeo_pkg::cov_t out_cov_r, cov_nxt;

  gaeo_pkg::coord_t  px, py, dxl, dxr, dy;
  logic signed [21:0] sqxl, sqxr, sqy;
  logic [18:0]        dl, dr;
  logic               in_band, f1, f2, b1, b2;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gaeo_pkg::REG_PAUSE_TICKS:  cfg_nxt.pause_ticks  = cfg_wdata;
        gaeo_pkg::REG_DISC_RAD:     cfg_nxt.disc_rad     = cfg_wdata[5:0];
        gaeo_pkg::REG_BORDER_WIDTH: cfg_nxt.border_width = cfg_wdata[3:0];
        gaeo_pkg::REG_LEFT_EYE_X:   cfg_nxt.left_eye_x   = cfg_wdata[7:0];
        gaeo_pkg::REG_RIGHT_EYE_X:  cfg_nxt.right_eye_x  = cfg_wdata[7:0];
        gaeo_pkg::REG_EYE_CENTRE_Y: cfg_nxt.eye_centre_y = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pause_ticks  <= gaeo_pkg::RST_PAUSE_TICKS;
      cfg_r.disc_rad     <= gaeo_pkg::RST_DISC_RAD;
      cfg_r.border_width <= gaeo_pkg::RST_BORDER_WIDTH;
      cfg_r.left_eye_x   <= gaeo_pkg::RST_LEFT_EYE_X;
      cfg_r.right_eye_x  <= gaeo_pkg::RST_RIGHT_EYE_X;
      cfg_r.eye_centre_y <= gaeo_pkg::RST_EYE_CENTRE_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // handshake and pipeline control
  assign s1_go     = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || s1_go;
  assign in_xfer   = in_valid && in_ready;
  assign pix_xfer  = in_xfer && (in_op == gaeo_pkg::OP_PIXEL);
  assign tick_xfer = in_xfer && (in_op == gaeo_pkg::OP_TICK);
  assign s1_v_nxt  = in_ready ? pix_xfer : s1_v_r;
  assign out_v_nxt = s1_go ? s1_v_r : out_v_r;

  gaeo_gaze #(
    .MOVE_TICKS (MOVE_TICKS)
  ) u_gaze (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick_xfer),
    .pause_ticks (cfg_r.pause_ticks),
    .ofs         (ofs)
  );

  gaeo_geom u_geom (
    .clk  (clk),
    .cfg  (cfg_r),
    .ofs  (ofs),
    .geom (geom)
  );

  // pixel shading
  always_comb begin
    px   = $signed({3'b000, s1_x_r});
    py   = $signed({3'b000, s1_y_r});
    dxl  = px - geom.exl;
    dxr  = px - geom.exr;
    dy   = py - geom.cy;
    sqxl = dxl * dxl;
    sqxr = dxr * dxr;
    sqy  = dy * dy;
    dl   = {1'b0, sqxl[17:0]} + {1'b0, sqy[17:0]};
    dr   = {1'b0, sqxr[17:0]} + {1'b0, sqy[17:0]};
    in_band = (px >= geom.x0) && (px < geom.x1) && (py >= geom.y0) && (py < geom.y1);
    f1 = (dl <= {6'd0, geom.r2});
    f2 = (dr <= {6'd0, geom.r2});
    b1 = (dl <= {6'd0, geom.rb2}) && !f1;
    b2 = (dr <= {6'd0, geom.rb2}) && !f2;

    shaded_nxt = s1_bg_r;
    cov_nxt    = gaeo_pkg::COV_NONE;
    if (in_band) begin
      priority if (b1 || b2) begin
        shaded_nxt = gaeo_pkg::RING_RGB;
        cov_nxt    = gaeo_pkg::COV_BORDER;
      end else if (f1 || f2) begin
        shaded_nxt = gaeo_pkg::DISC_RGB;
        cov_nxt    = gaeo_pkg::COV_FILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      s1_x_r  <= in_pixel_x;
      s1_y_r  <= in_pixel_y;
      s1_bg_r <= in_background;
    end
    if (s1_go && s1_v_r) begin
      out_shaded_r <= shaded_nxt;
      out_cov_r    <= cov_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_shaded   = out_shaded_r;
  assign out_coverage = out_cov_r;

endmodule

>>> hw/rtl/gaeo_chk.sv
// port-level checker for the eye overlay unit and its bind
`include "gaze_animated_eye_overlay_unit_defines.svh"

module gaeo_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_shaded,
  input logic [1:0]  out_coverage
);

  // stalled result holds
  `GAEO_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_shaded) && $stable(out_coverage))

  // an empty result register never blocks input
  `GAEO_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

  // coverage code and colour agree
  `GAEO_ASSERT_IMP(a_cov_colour,
    out_valid && out_coverage != gaeo_pkg::COV_NONE,
    (out_coverage == gaeo_pkg::COV_BORDER && out_shaded == gaeo_pkg::RING_RGB) ||
    (out_coverage == gaeo_pkg::COV_FILL && out_shaded == gaeo_pkg::DISC_RGB))

  // a pixel transfer followed by out_ready yields a valid result
  `GAEO_ASSERT_NXT(a_pixel_result,
    in_valid && in_ready && in_op == gaeo_pkg::OP_PIXEL ##1 out_ready, out_valid)

endmodule

bind gaze_animated_eye_overlay_unit gaeo_chk u_chk (.*);

>>> test/gaze_animated_eye_overlay_unit_checker.sv
// checker for the eye overlay unit: tracks gaze and registers, predicts shading, compares
module gaze_animated_eye_overlay_unit_checker
  import gaeo_pkg::*;
#(
  parameter int GLIDE_TICKS = MOVE_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_op,
  input  logic [7:0]            in_pixel_x,
  input  logic [7:0]            in_pixel_y,
  input  logic [15:0]           in_background,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [15:0]           out_shaded,
  input  logic [1:0]            out_coverage,
  output int                    fail_count,
  output int                    awaiting,
  output int                    pixel_count,
  output int                    tick_count,
  output int                    shade_count
);

  localparam int LOOK_SWING = 12;
  localparam int LOOK_DX [8] = '{0, -12, 12, 0, 0, 0, 0, 0};
  localparam int LOOK_DY [8] = '{0, 0, 0, 10, -10, 0, 0, 0};

  typedef struct packed {
    logic [15:0] shaded;
    cov_t        coverage;
  } shade_t;

  shade_t expected_shades[$];

  logic [15:0] pause_q;
  logic [5:0]  radius_q;
  logic [3:0]  border_q;
  logic [7:0]  left_x_q;
  logic [7:0]  right_x_q;
  logic [7:0]  centre_y_q;

  int unsigned since_move;
  int          gaze_at;
  int          gaze_to;
  bit          gliding;
  int          gaze_ox;
  int          gaze_oy;

  function automatic int glide(input int from, input int to, input int e);
    return (from * GLIDE_TICKS + (to - from) * e) / GLIDE_TICKS;
  endfunction

  task automatic advance_gaze();
    if (since_move < 65535) since_move++;
    if (!gliding && since_move > pause_q) begin
      gaze_to = ((gaze_at + 1) % GAZE_COUNT) & 7;
      since_move = 0;
      gliding = 1'b1;
    end
    if (gliding) begin
      if (since_move >= GLIDE_TICKS) begin
        gliding = 1'b0;
        gaze_at = gaze_to;
        since_move = 0;
        gaze_ox = LOOK_DX[gaze_to];
        gaze_oy = LOOK_DY[gaze_to];
      end else begin
        gaze_ox = glide(LOOK_DX[gaze_at], LOOK_DX[gaze_to], since_move);
        gaze_oy = glide(LOOK_DY[gaze_at], LOOK_DY[gaze_to], since_move);
      end
    end else begin
      gaze_ox = LOOK_DX[gaze_at];
      gaze_oy = LOOK_DY[gaze_at];
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_PAUSE_TICKS:  pause_q = val;
      REG_DISC_RAD:     radius_q = val[5:0];
      REG_BORDER_WIDTH: border_q = val[3:0];
      REG_LEFT_EYE_X:   left_x_q = val[7:0];
      REG_RIGHT_EYE_X:  right_x_q = val[7:0];
      REG_EYE_CENTRE_Y: centre_y_q = val[7:0];
      default: ;
    endcase
  endtask

  function automatic shade_t shade_pixel(input logic [7:0] px, input logic [7:0] py,
                                         input logic [15:0] bg);
    int x, y, r, rb, x0, w, y0, h, cyy, exl, exr, d1, d2;
    bit f1, f2, b1, b2;
    shade_t res;
    x = px;
    y = py;
    r = radius_q;
    rb = r + int'(border_q);
    x0 = int'(left_x_q) - LOOK_SWING - rb - 1;
    w = (int'(right_x_q) + LOOK_SWING + rb + 1) - x0;
    y0 = int'(centre_y_q) - rb - 1;
    h = 2 * (rb + 1);
    if (x0 < BAND_MIN_X) x0 = BAND_MIN_X;
    if (y0 < BAND_MIN_Y) y0 = BAND_MIN_Y;
    if (x0 + w > BAND_END_X) w = BAND_END_X - x0;
    if (y0 + h > BAND_END_Y) h = BAND_END_Y - y0;
    res.shaded = bg;
    res.coverage = COV_NONE;
    if (x < x0 || x >= x0 + w || y < y0 || y >= y0 + h) return res;
    cyy = int'(centre_y_q) + gaze_oy;
    exl = int'(left_x_q) + gaze_ox;
    exr = int'(right_x_q) + gaze_ox;
    d1 = (x - exl) * (x - exl) + (y - cyy) * (y - cyy);
    d2 = (x - exr) * (x - exr) + (y - cyy) * (y - cyy);
    f1 = d1 <= r * r;
    f2 = d2 <= r * r;
    b1 = d1 <= rb * rb && !f1;
    b2 = d2 <= rb * rb && !f2;
    if (b1 || b2) begin
      res.shaded = RING_RGB;
      res.coverage = COV_BORDER;
    end else if (f1 || f2) begin
      res.shaded = DISC_RGB;
      res.coverage = COV_FILL;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    shade_t got;
    shade_t want;
    if (!rst_n) begin
      pause_q = RST_PAUSE_TICKS;
      radius_q = RST_DISC_RAD;
      border_q = RST_BORDER_WIDTH;
      left_x_q = RST_LEFT_EYE_X;
      right_x_q = RST_RIGHT_EYE_X;
      centre_y_q = RST_EYE_CENTRE_Y;
      since_move = 0;
      gaze_at = 0;
      gaze_to = 0;
      gliding = 1'b0;
      gaze_ox = 0;
      gaze_oy = 0;
      expected_shades.delete();
      fail_count = 0;
      pixel_count = 0;
      tick_count = 0;
      shade_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.shaded = out_shaded;
        got.coverage = cov_t'(out_coverage);
        if (expected_shades.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transfer: shaded %h coverage %0d",
                     out_shaded, out_coverage);
          fail_count++;
        end else begin
          want = expected_shades.pop_front();
          shade_count++;
          if (got.shaded !== want.shaded || got.coverage !== want.coverage) begin
            if (fail_count < 10)
              $display("shade mismatch: expected shaded %h coverage %0d, got %h %0d",
                       want.shaded, want.coverage, out_shaded, out_coverage);
            fail_count++;
          end
        end
      end
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        if (in_op == OP_PIXEL) begin
          expected_shades.push_back(shade_pixel(in_pixel_x, in_pixel_y, in_background));
          pixel_count++;
        end else begin
          advance_gaze();
          tick_count++;
        end
      end
    end
    awaiting <= expected_shades.size();
  end

endmodule

>>> test/gaze_animated_eye_overlay_unit_tb.sv
// testbench top for the eye overlay unit: clock, reset, stimulus and verdict
module gaze_animated_eye_overlay_unit_tb;
  import gaeo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [7:0]            in_pixel_x;
  logic [7:0]            in_pixel_y;
  logic [15:0]           in_background;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [15:0]           out_shaded;
  logic [1:0]            out_coverage;

  int fail_count, awaiting, pixel_count, tick_count, shade_count;
  int settings;
  int stall_left = 0;
  bit calm = 1'b0;

  logic [5:0] cur_rad;
  logic [3:0] cur_bw;
  logic [7:0] cur_lx, cur_rx, cur_cy;

  gaze_animated_eye_overlay_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y), .in_background(in_background),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_shaded(out_shaded), .out_coverage(out_coverage)
  );

  gaze_animated_eye_overlay_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y), .in_background(in_background),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_shaded(out_shaded), .out_coverage(out_coverage),
    .fail_count(fail_count), .awaiting(awaiting), .pixel_count(pixel_count),
    .tick_count(tick_count), .shade_count(shade_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side stalls in short bursts outside the calm phase
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] px, input logic [7:0] py,
                           input logic [15:0] bg);
    bit took;
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_background <= bg;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_item(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic random_pixel();
    int reach, ex, x, y;
    logic [15:0] bg;
    reach = int'(cur_rad) + int'(cur_bw) + 16;
    ex = $urandom_range(0, 1) ? int'(cur_rx) : int'(cur_lx);
    if ($urandom_range(0, 99) < 85) begin
      x = ex + int'($urandom_range(0, 2 * reach)) - reach;
      y = int'(cur_cy) + int'($urandom_range(0, 2 * reach)) - reach;
    end else begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
    end
    case ($urandom_range(0, 9))
      0: bg = 16'h0000;
      1: bg = 16'hFFFF;
      default: bg = 16'($urandom);
    endcase
    send_item(OP_PIXEL, x[7:0], y[7:0], bg);
  endtask

  task automatic random_phase(input int pixels);
    repeat (pixels) begin
      if ($urandom_range(0, 5) == 0) run_ticks($urandom_range(1, 8));
      random_pixel();
    end
  endtask

  // wait until every pixel has come back, then let the pipeline empty
  task automatic settle(input int extra);
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // upper bits of narrow registers carry junk that must be masked off
  task automatic set_regs(input logic [15:0] pause, input logic [5:0] rad, input logic [3:0] bw,
                          input logic [7:0] lx, input logic [7:0] rx, input logic [7:0] cy);
    in_valid <= 1'b0;
    settle(4);
    put_reg(REG_PAUSE_TICKS, pause);
    put_reg(REG_DISC_RAD, {10'($urandom), rad});
    put_reg(REG_BORDER_WIDTH, {12'($urandom), bw});
    put_reg(REG_LEFT_EYE_X, {8'($urandom), lx});
    put_reg(REG_RIGHT_EYE_X, {8'($urandom), rx});
    put_reg(REG_EYE_CENTRE_Y, {8'($urandom), cy});
    put_reg(REG_SPARE_6, 16'($urandom));
    put_reg(REG_SPARE_7, 16'($urandom));
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
    cur_rad = rad;
    cur_bw = bw;
    cur_lx = lx;
    cur_rx = rx;
    cur_cy = cy;
    settings++;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = OP_TICK;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_background = '0;
    settings = 1;
    cur_rad = RST_DISC_RAD;
    cur_bw = RST_BORDER_WIDTH;
    cur_lx = RST_LEFT_EYE_X;
    cur_rx = RST_RIGHT_EYE_X;
    cur_cy = RST_EYE_CENTRE_Y;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed checks at reset settings
    send_item(OP_PIXEL, 8'd70, 8'd160, 16'h0000);
    send_item(OP_PIXEL, 8'd160, 8'd160, 16'hFFFF);
    send_item(OP_PIXEL, 8'd96, 8'd160, 16'h1234);
    send_item(OP_PIXEL, 8'd70, 8'd132, 16'hABCD);
    send_item(OP_PIXEL, 8'd94, 8'd160, 16'h5555);
    send_item(OP_PIXEL, 8'd70, 8'd189, 16'hAAAA);
    send_item(OP_PIXEL, 8'd28, 8'd160, 16'hFFFF);
    send_item(OP_PIXEL, 8'd29, 8'd160, 16'h0F0F);
    send_item(OP_PIXEL, 8'd115, 8'd160, 16'hF0F0);
    send_item(OP_PIXEL, 8'd0, 8'd0, 16'hFFFF);
    send_item(OP_PIXEL, 8'd255, 8'd255, 16'h0000);
    send_item(OP_PIXEL, 8'd255, 8'd0, 16'h8001);
    send_item(OP_PIXEL, 8'd0, 8'd255, 16'h7FFE);
    send_item(OP_TICK, 8'd255, 8'd255, 16'hFFFF);
    send_item(OP_TICK, 8'd0, 8'd0, 16'h0000);
    run_ticks(3);
    send_item(OP_PIXEL, 8'd184, 8'd160, 16'h0001);

    set_regs(16'd5, 6'd24, 4'd4, 8'd70, 8'd160, 8'd160);
    random_phase(60);
    // band starts raised and ends cut at the far edges
    set_regs(16'd0, 6'd63, 4'd15, 8'd10, 8'd250, 8'd20);
    random_phase(50);
    // eyes swapped so the band is empty, and the longest pause
    set_regs(16'hFFFF, 6'd1, 4'd0, 8'd255, 8'd0, 8'd255);
    random_phase(30);
    set_regs(16'd100, 6'd0, 4'd7, 8'd40, 8'd200, 8'd60);
    random_phase(50);
    repeat (4) begin
      set_regs(16'($urandom_range(0, 20)), 6'($urandom_range(1, 63)),
               4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom), 8'($urandom));
      random_phase(30);
    end
    // longest pause again with a mid-size geometry
    set_regs(16'hFFFF, 6'd30, 4'd5, 8'd80, 8'd150, 8'd120);
    random_phase(20);

    calm = 1'b1;
    set_regs(16'd1, 6'd20, 4'd3, 8'd90, 8'd140, 8'd130);
    random_phase(40);

    in_valid <= 1'b0;
    settle(8);
    $display("run covered %0d pixels and %0d ticks over %0d register settings",
             pixel_count, tick_count, settings);
    $display("%0d shaded results compared, %0d failures", shade_count, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/gaeo_pkg.sv
hw/rtl/gaeo_gaze.sv
hw/rtl/gaeo_geom.sv
hw/rtl/gaze_animated_eye_overlay_unit.sv
hw/rtl/gaeo_chk.sv
test/gaze_animated_eye_overlay_unit_checker.sv
test/gaze_animated_eye_overlay_unit_tb.sv
